/* rtl/core/discovery_peer_table_with_aging_macros.svh */
// Assertion macros for the peer table checker.
`ifndef DISCOVERY_PEER_TABLE_WITH_AGING_MACROS_SVH
`define DISCOVERY_PEER_TABLE_WITH_AGING_MACROS_SVH

// Check a property on the rising clock edge, off while reset is asserted.
`define DPTA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define DPTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/dpta_pkg.sv */
package dpta_pkg;

	// Field widths fixed by the interface
	localparam int SLOT_W  = 4;
	localparam int CNT_W   = 5;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int INDEX_W = 32;
	localparam int DATA_W  = 64;
	localparam int TIME_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd5000;
	localparam logic [CNT_W-1:0]  EVICT_MAX   = 5'd31;
	localparam logic [CNT_W-1:0]  EVICT_ONE   = 5'd1;

	// Register select: address bit 3 picks the register
	localparam logic REG_APP_ID  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		REQ_PACKET = 2'd0,
		REQ_SWEEP  = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IGNORED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_UPDATED   = 3'd2,
		ST_REFRESHED = 3'd3,
		ST_FULL      = 3'd4,
		ST_SWEPT     = 3'd5,
		ST_READ      = 3'd6
	} status_t;

	// What the cells do while the token passes them
	typedef enum logic [2:0] {
		OP_SEARCH  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_UPDATE  = 3'd2,
		OP_REFRESH = 3'd3,
		OP_SWEEP   = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	// Command held steady for all cells during a pass
	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  now;
		logic [IP_W-1:0]    ip;
		logic [PORT_W-1:0]  port;
		logic [INDEX_W-1:0] pidx;
		logic               ireset;
		logic [DATA_W-1:0]  word;
		logic [SLOT_W-1:0]  rslot;
		logic [TIME_W-1:0]  timeout;
	} bcast_t;

	// Token handed from cell to cell
	typedef struct packed {
		logic               vld;
		logic               hit;
		logic               newer;
		logic               free;
		logic [SLOT_W-1:0]  hit_slot;
		logic [SLOT_W-1:0]  free_slot;
		logic [CNT_W-1:0]   evicted;
		logic               rd_valid;
		logic [IP_W-1:0]    rd_ip;
		logic [PORT_W-1:0]  rd_port;
		logic [INDEX_W-1:0] rd_index;
		logic [DATA_W-1:0]  rd_data;
	} tok_t;

endpackage

/* rtl/core/dpta_regs.sv */
module dpta_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dpta_pkg::ADDR_W-1:0]   paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	output logic [63:0]                   app_id,
	output logic [dpta_pkg::TIME_W-1:0]   age_limit
);

	logic [63:0]                 app_id_q;
	logic [dpta_pkg::TIME_W-1:0] timeout_q;
	logic                        wr_en;
	logic                        sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = paddr[3];

	// Write the selected register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_id_q  <= '0;
			timeout_q <= dpta_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			if (sel == dpta_pkg::REG_APP_ID) begin
				app_id_q <= pwdata;
			end else begin
				timeout_q <= pwdata[dpta_pkg::TIME_W-1:0];
			end
		end
	end

	// Return the selected register
	always_comb begin
		if (sel == dpta_pkg::REG_APP_ID) begin
			prdata = app_id_q;
		end else begin
			prdata = {32'd0, timeout_q};
		end
	end

	assign app_id    = app_id_q;
	assign age_limit = timeout_q;

endmodule

/* rtl/core/dpta_cell.sv */
module dpta_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dpta_pkg::bcast_t bc,
	input  dpta_pkg::tok_t   tok_in,
	output dpta_pkg::tok_t   tok_out
);

	localparam bit IDX_IN = (IDX < (1 << dpta_pkg::SLOT_W));
	localparam logic [dpta_pkg::SLOT_W-1:0] IDX_LO = IDX[dpta_pkg::SLOT_W-1:0];

	logic                           live_q;
	logic                           hit_mark_q;
	logic                           free_mark_q;
	logic [dpta_pkg::IP_W-1:0]      ip_q;
	logic [dpta_pkg::PORT_W-1:0]    port_q;
	logic [dpta_pkg::INDEX_W-1:0]   index_q;
	logic [dpta_pkg::DATA_W-1:0]    data_q;
	logic [dpta_pkg::TIME_W-1:0]    seen_q;
	dpta_pkg::tok_t                 tok_q;

	dpta_pkg::tok_t                 tok_nx;
	logic [dpta_pkg::TIME_W-1:0]    age;
	logic                           key_eq;
	logic                           stale;
	logic                           rd_hit;
	logic                           is_target;
	logic                           ageable;
	logic                           do_evict;
	logic                           search;
	logic                           new_hit;
	logic                           new_free;

	assign key_eq   = (ip_q == bc.ip) && (port_q == bc.port);
	assign age      = bc.now - seen_q;
	assign stale    = live_q && (age > bc.timeout);
	assign rd_hit   = IDX_IN && (bc.rslot == IDX_LO) && live_q;
	assign search   = tok_in.vld && (bc.op == dpta_pkg::OP_SEARCH);
	assign new_hit  = live_q && key_eq && !tok_in.hit;
	assign new_free = !live_q && !tok_in.free;

	// Decide whether this cell is the one the packet acts on
	always_comb begin
		is_target = 1'b0;
		ageable   = 1'b0;
		case (bc.op)
			dpta_pkg::OP_INSERT: begin
				is_target = free_mark_q;
				ageable   = 1'b1;
			end
			dpta_pkg::OP_UPDATE, dpta_pkg::OP_REFRESH: begin
				is_target = hit_mark_q;
				ageable   = 1'b1;
			end
			dpta_pkg::OP_SWEEP: begin
				ageable = 1'b1;
			end
			default: begin
				is_target = 1'b0;
				ageable   = 1'b0;
			end
		endcase
	end

	assign do_evict = tok_in.vld && ageable && !is_target && stale;

	// Fold this cell into the passing token
	always_comb begin
		tok_nx = tok_in;
		if (tok_in.vld) begin
			case (bc.op)
				dpta_pkg::OP_SEARCH: begin
					if (new_hit) begin
						tok_nx.hit      = 1'b1;
						tok_nx.newer    = bc.ireset || (index_q < bc.pidx);
						tok_nx.hit_slot = IDX_LO;
					end
					if (new_free) begin
						tok_nx.free      = 1'b1;
						tok_nx.free_slot = IDX_LO;
					end
				end
				dpta_pkg::OP_READ: begin
					if (rd_hit) begin
						tok_nx.rd_valid = 1'b1;
						tok_nx.rd_ip    = ip_q;
						tok_nx.rd_port  = port_q;
						tok_nx.rd_index = index_q;
						tok_nx.rd_data  = data_q;
					end
				end
				default: begin
					if (do_evict && (tok_in.evicted != dpta_pkg::EVICT_MAX)) begin
						tok_nx.evicted = tok_in.evicted + dpta_pkg::EVICT_ONE;
					end
				end
			endcase
		end
	end

	// Advance the token, mark search results, track liveness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			live_q      <= 1'b0;
			hit_mark_q  <= 1'b0;
			free_mark_q <= 1'b0;
		end else begin
			tok_q <= tok_nx;
			if (search) begin
				hit_mark_q  <= new_hit;
				free_mark_q <= new_free;
			end
			if (tok_in.vld && is_target && (bc.op == dpta_pkg::OP_INSERT)) begin
				live_q <= 1'b1;
			end else if (do_evict) begin
				live_q <= 1'b0;
			end
		end
	end

	// Write the entry contents
	always_ff @(posedge clk) begin
		if (tok_in.vld && is_target) begin
			seen_q <= bc.now;
			if (bc.op == dpta_pkg::OP_INSERT) begin
				ip_q   <= bc.ip;
				port_q <= bc.port;
			end
			if ((bc.op == dpta_pkg::OP_INSERT) || (bc.op == dpta_pkg::OP_UPDATE)) begin
				index_q <= bc.pidx;
				data_q  <= bc.word;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/core/dpta_ctrl.sv */
module dpta_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [dpta_pkg::TIME_W-1:0]   now_ms,
	input  logic                          header_ok,
	input  logic [63:0]                   pkt_app_id,
	input  logic [dpta_pkg::IP_W-1:0]     src_ip,
	input  logic [dpta_pkg::PORT_W-1:0]   src_port,
	input  logic [dpta_pkg::INDEX_W-1:0]  pkt_index,
	input  logic                          index_reset,
	input  logic [dpta_pkg::DATA_W-1:0]   payload_word,
	input  logic [dpta_pkg::SLOT_W-1:0]   read_slot,
	input  logic [63:0]                   app_id,
	input  logic [dpta_pkg::TIME_W-1:0]   age_limit,
	output dpta_pkg::bcast_t              bc,
	output dpta_pkg::tok_t                head,
	input  dpta_pkg::tok_t                tail,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [dpta_pkg::SLOT_W-1:0]   slot,
	output logic [dpta_pkg::CNT_W-1:0]    evicted_count,
	output logic                          entry_valid,
	output logic [dpta_pkg::IP_W-1:0]     entry_ip,
	output logic [dpta_pkg::PORT_W-1:0]   entry_port,
	output logic [dpta_pkg::INDEX_W-1:0]  entry_index,
	output logic [dpta_pkg::DATA_W-1:0]   entry_data
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_APPLY  = 3'b100
	} state_t;

	state_t                         state_q;
	dpta_pkg::op_t                  op_q;
	logic                           inj_q;
	logic                           done_q;
	dpta_pkg::status_t              stat_q;
	logic [dpta_pkg::SLOT_W-1:0]    slot_q;
	logic [dpta_pkg::TIME_W-1:0]    now_q;
	logic [dpta_pkg::IP_W-1:0]      ip_q;
	logic [dpta_pkg::PORT_W-1:0]    port_q;
	logic [dpta_pkg::INDEX_W-1:0]   pidx_q;
	logic                           ireset_q;
	logic [dpta_pkg::DATA_W-1:0]    word_q;
	logic [dpta_pkg::SLOT_W-1:0]    rslot_q;

	dpta_pkg::status_t              res_status_q;
	logic [dpta_pkg::SLOT_W-1:0]    res_slot_q;
	logic [dpta_pkg::CNT_W-1:0]     res_evicted_q;
	logic                           res_valid_q;
	logic [dpta_pkg::IP_W-1:0]      res_ip_q;
	logic [dpta_pkg::PORT_W-1:0]    res_port_q;
	logic [dpta_pkg::INDEX_W-1:0]   res_index_q;
	logic [dpta_pkg::DATA_W-1:0]    res_data_q;

	logic                           accept;
	logic                           pkt_ok;
	logic                           finish_now;
	logic                           finish_pass;

	assign accept      = start && (state_q == S_IDLE);
	assign pkt_ok      = header_ok && (pkt_app_id == app_id);
	assign finish_pass = (state_q == S_APPLY) && tail.vld;

	// Rejected packets and unused requests answer at once
	always_comb begin
		finish_now = 1'b0;
		if (accept) begin
			case (dpta_pkg::req_t'(req_type))
				dpta_pkg::REQ_PACKET: finish_now = !pkt_ok;
				dpta_pkg::REQ_NONE:   finish_now = 1'b1;
				default:              finish_now = 1'b0;
			endcase
		end
	end

	// Sequence the passes over the cell row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= dpta_pkg::OP_SEARCH;
			inj_q   <= 1'b0;
			done_q  <= 1'b0;
			stat_q  <= dpta_pkg::ST_IGNORED;
			slot_q  <= '0;
		end else begin
			inj_q  <= 1'b0;
			done_q <= finish_now || finish_pass;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (dpta_pkg::req_t'(req_type))
							dpta_pkg::REQ_PACKET: begin
								if (pkt_ok) begin
									op_q    <= dpta_pkg::OP_SEARCH;
									inj_q   <= 1'b1;
									state_q <= S_SEARCH;
								end
							end
							dpta_pkg::REQ_SWEEP: begin
								op_q    <= dpta_pkg::OP_SWEEP;
								stat_q  <= dpta_pkg::ST_SWEPT;
								slot_q  <= '0;
								inj_q   <= 1'b1;
								state_q <= S_APPLY;
							end
							dpta_pkg::REQ_READ: begin
								op_q    <= dpta_pkg::OP_READ;
								stat_q  <= dpta_pkg::ST_READ;
								slot_q  <= read_slot;
								inj_q   <= 1'b1;
								state_q <= S_APPLY;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SEARCH: begin
					// Pick the action from the search token
					if (tail.vld) begin
						inj_q   <= 1'b1;
						state_q <= S_APPLY;
						if (tail.hit) begin
							slot_q <= tail.hit_slot;
							if (tail.newer) begin
								op_q   <= dpta_pkg::OP_UPDATE;
								stat_q <= dpta_pkg::ST_UPDATED;
							end else begin
								op_q   <= dpta_pkg::OP_REFRESH;
								stat_q <= dpta_pkg::ST_REFRESHED;
							end
						end else if (tail.free) begin
							op_q   <= dpta_pkg::OP_INSERT;
							stat_q <= dpta_pkg::ST_INSERTED;
							slot_q <= tail.free_slot;
						end else begin
							op_q   <= dpta_pkg::OP_SWEEP;
							stat_q <= dpta_pkg::ST_FULL;
							slot_q <= '0;
						end
					end
				end
				S_APPLY: begin
					if (tail.vld) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted command for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= now_ms;
			ip_q     <= src_ip;
			port_q   <= src_port;
			pidx_q   <= pkt_index;
			ireset_q <= index_reset;
			word_q   <= payload_word;
			rslot_q  <= read_slot;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (finish_now) begin
			res_status_q  <= dpta_pkg::ST_IGNORED;
			res_slot_q    <= '0;
			res_evicted_q <= '0;
			res_valid_q   <= 1'b0;
			res_ip_q      <= '0;
			res_port_q    <= '0;
			res_index_q   <= '0;
			res_data_q    <= '0;
		end else if (finish_pass) begin
			res_status_q  <= stat_q;
			res_slot_q    <= slot_q;
			res_evicted_q <= tail.evicted;
			res_valid_q   <= tail.rd_valid;
			res_ip_q      <= tail.rd_ip;
			res_port_q    <= tail.rd_port;
			res_index_q   <= tail.rd_index;
			res_data_q    <= tail.rd_data;
		end
	end

	// Drive the cell row
	always_comb begin
		bc.op      = op_q;
		bc.now     = now_q;
		bc.ip      = ip_q;
		bc.port    = port_q;
		bc.pidx    = pidx_q;
		bc.ireset  = ireset_q;
		bc.word    = word_q;
		bc.rslot   = rslot_q;
		bc.timeout = age_limit;
		head       = '0;
		head.vld   = inj_q;
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = res_status_q;
	assign slot          = res_slot_q;
	assign evicted_count = res_evicted_q;
	assign entry_valid   = res_valid_q;
	assign entry_ip      = res_ip_q;
	assign entry_port    = res_port_q;
	assign entry_index   = res_index_q;
	assign entry_data    = res_data_q;

endmodule

/* rtl/core/discovery_peer_table_with_aging.sv */
// Channel   Handshake                 Payload
// config    psel/penable/pwrite/pready paddr, pwdata, prdata (64 bit)
// request   start while busy is low   req_type ... read_slot
// result    done, one cycle           status ... entry_data
//
// A packet that passes the header check takes two passes of the cell row
// from start to the next start: one for the lookup, one for the write and
// aging; each cell registers the token. A sweep or a read takes a single
// pass, a rejected packet or an unused request no pass.
// Reset is asynchronous and clears every slot; no clearing pass follows.
// Results stay until the next request finishes; done marks a single cycle.
module discovery_peer_table_with_aging #(
	parameter int MAX_PEERS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dpta_pkg::ADDR_W-1:0]   paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [dpta_pkg::TIME_W-1:0]   now_ms,
	input  logic                          header_ok,
	input  logic [63:0]                   pkt_app_id,
	input  logic [dpta_pkg::IP_W-1:0]     src_ip,
	input  logic [dpta_pkg::PORT_W-1:0]   src_port,
	input  logic [dpta_pkg::INDEX_W-1:0]  pkt_index,
	input  logic                          index_reset,
	input  logic [dpta_pkg::DATA_W-1:0]   payload_word,
	input  logic [dpta_pkg::SLOT_W-1:0]   read_slot,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [dpta_pkg::SLOT_W-1:0]   slot,
	output logic [dpta_pkg::CNT_W-1:0]    evicted_count,
	output logic                          entry_valid,
	output logic [dpta_pkg::IP_W-1:0]     entry_ip,
	output logic [dpta_pkg::PORT_W-1:0]   entry_port,
	output logic [dpta_pkg::INDEX_W-1:0]  entry_index,
	output logic [dpta_pkg::DATA_W-1:0]   entry_data
);

	logic [63:0]                 app_id;
	logic [dpta_pkg::TIME_W-1:0] age_limit;
	dpta_pkg::bcast_t            bc;
	dpta_pkg::tok_t              chain [MAX_PEERS+1];

	dpta_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.app_id    (app_id),
		.age_limit (age_limit)
	);

	dpta_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.now_ms        (now_ms),
		.header_ok     (header_ok),
		.pkt_app_id    (pkt_app_id),
		.src_ip        (src_ip),
		.src_port      (src_port),
		.pkt_index     (pkt_index),
		.index_reset   (index_reset),
		.payload_word  (payload_word),
		.read_slot     (read_slot),
		.app_id        (app_id),
		.age_limit     (age_limit),
		.bc            (bc),
		.head          (chain[0]),
		.tail          (chain[MAX_PEERS]),
		.done          (done),
		.status        (status),
		.slot          (slot),
		.evicted_count (evicted_count),
		.entry_valid   (entry_valid),
		.entry_ip      (entry_ip),
		.entry_port    (entry_port),
		.entry_index   (entry_index),
		.entry_data    (entry_data)
	);

	// One cell per table slot, token runs from slot 0 upward
	for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
		dpta_cell #(
			.IDX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

endmodule

/* rtl/core/dpta_checker.sv */
`include "discovery_peer_table_with_aging_macros.svh"

module dpta_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [1:0]                  req_type,
	input logic                        done,
	input logic [2:0]                  status,
	input logic [dpta_pkg::CNT_W-1:0]  evicted_count,
	input logic                        entry_valid,
	input logic [dpta_pkg::DATA_W-1:0] entry_data
);

	// busy only rises after a start word
	`DPTA_ASSERT(a_busy_after_start, clk, arst_n, $rose(busy) |-> $past(start), "busy rose without start")

	// sweeps and reads always run through the cell row
	`DPTA_ASSERT(a_pass_taken, clk, arst_n, (start && !busy && (req_type == dpta_pkg::REQ_SWEEP || req_type == dpta_pkg::REQ_READ)) |=> busy, "sweep or read did not go busy")

	// entry fields only carry data on read words
	`DPTA_ASSERT(a_entry_only_read, clk, arst_n, (done && status != dpta_pkg::ST_READ) |-> (!entry_valid && entry_data == '0), "entry fields set on non-read word")

	// ignored and read words never report evictions
	`DPTA_ASSERT(a_no_evict_count, clk, arst_n, (done && (status == dpta_pkg::ST_IGNORED || status == dpta_pkg::ST_READ)) |-> (evicted_count == '0), "evictions on ignored or read word")

endmodule

bind discovery_peer_table_with_aging dpta_checker u_chk (.*);
